[src/bole_pkg.sv]
`default_nettype none

package bole_pkg;

  // Field widths of the two channels
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Action codes carried by in_action
  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_POS   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ_ALL  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL   = 2'd3;

  // Operation issued by the controller to the datapath
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_DEL_FRONT,
    OP_DEL_BACK,
    OP_DEL_POS,
    OP_DUMP,
    OP_REPORT
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] status;    // status for OP_REPORT
    logic                shift_en;  // run the compaction stream
    logic                dump_en;   // run the read-out stream
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_ok;       // in_position lies in 1..count
    logic no_moves;     // in_position is the back entry
    logic stream_idle;  // nothing left to read or write back
    logic out_busy;     // result register held by a stall
  } dp_sts_t;

endpackage

`default_nettype wire

[src/bole_datapath.sv]
`default_nettype none

module bole_datapath #(
  parameter int DEPTH = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  bole_pkg::dp_cmd_t                 cmd,
  output bole_pkg::dp_sts_t                 sts,
  input  wire signed [bole_pkg::VALUE_W-1:0] in_value,
  input  wire [bole_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [bole_pkg::STATUS_W-1:0]     out_status,
  output logic signed [bole_pkg::VALUE_W-1:0] out_element,
  output logic                              out_element_valid,
  output logic                              out_last,
  output logic [bole_pkg::LEN_W-1:0]        out_length
);

  import bole_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Circular store and its registered read port
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  logic [SLOT_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic              last_pend_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_element_r;
  logic                out_element_valid_r;
  logic                out_last_r;
  logic [LEN_W-1:0]    out_length_r;

  logic                mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [VALUE_W-1:0]  mem_wd;
  logic                single_load;
  logic [STATUS_W-1:0] single_status;

  logic [CNT_W-1:0]  pos_cnt;
  logic [SLOT_W-1:0] back_slot, next_front, prev_front, pos_slot, pos_slot_m1;
  logic              out_free, load_elem, rd_issue, shift_wr;

  // (a + b) mod DEPTH where the sum stays below twice DEPTH
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
    if (s >= SUM_W'(DEPTH)) begin
      return SLOT_W'(s - SUM_W'(DEPTH));
    end
    return SLOT_W'(s);
  endfunction

  function automatic logic [SLOT_W-1:0] inc_slot(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(DEPTH - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // Slot arithmetic; position only matters once it is known to be in range
  assign pos_cnt     = CNT_W'(in_position);
  assign back_slot   = wrap_slot(SUM_W'(front_r) + SUM_W'(count_r));
  assign next_front  = inc_slot(front_r);
  assign prev_front  = (front_r == '0) ? SLOT_W'(DEPTH - 1) : front_r - 1'b1;
  assign pos_slot    = wrap_slot(SUM_W'(front_r) + SUM_W'(pos_cnt));
  assign pos_slot_m1 = wrap_slot(SUM_W'(front_r) + SUM_W'(pos_cnt - 1'b1));

  // Stream control: at most one read and at most one write per cycle
  assign out_free  = !(out_valid_r && out_stall);
  assign load_elem = cmd.dump_en && pend_r && out_free;
  assign shift_wr  = cmd.shift_en && pend_r;
  assign rd_issue  = (cmd.shift_en || cmd.dump_en) && (rem_r != '0) &&
                     (cmd.shift_en || !pend_r || load_elem);

  always_comb begin
    if (rd_issue) begin
      pend_nxt = 1'b1;
    end else if (shift_wr || load_elem) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  // Status towards the controller
  always_comb begin
    sts.empty       = (count_r == '0);
    sts.full        = (count_r == CNT_W'(DEPTH));
    sts.pos_ok      = (in_position != '0) && (in_position <= POS_W'(count_r));
    sts.no_moves    = (in_position == POS_W'(count_r));
    sts.stream_idle = (rem_r == '0) && !pend_r;
    sts.out_busy    = !out_free;
  end

  // Next state of list pointers, stream counters and store write port
  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    rd_slot_nxt   = rd_slot_r;
    wr_slot_nxt   = wr_slot_r;
    mem_we        = 1'b0;
    mem_wa        = back_slot;
    mem_wd        = in_value;
    single_load   = 1'b0;
    single_status = STS_OK;
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_INS_FRONT: begin
        front_nxt   = prev_front;
        mem_we      = 1'b1;
        mem_wa      = prev_front;
        count_nxt   = count_r + 1'b1;
        single_load = 1'b1;
      end
      OP_INS_BACK: begin
        mem_we      = 1'b1;
        mem_wa      = back_slot;
        count_nxt   = count_r + 1'b1;
        single_load = 1'b1;
      end
      OP_DEL_FRONT: begin
        front_nxt   = next_front;
        count_nxt   = count_r - 1'b1;
        single_load = 1'b1;
      end
      OP_DEL_BACK: begin
        count_nxt   = count_r - 1'b1;
        single_load = 1'b1;
      end
      OP_DEL_POS: begin
        count_nxt   = count_r - 1'b1;
        wr_slot_nxt = pos_slot_m1;
        rd_slot_nxt = pos_slot;
        rem_nxt     = count_r - pos_cnt;
        single_load = 1'b1;
      end
      OP_DUMP: begin
        rd_slot_nxt = front_r;
        rem_nxt     = count_r;
      end
      OP_REPORT: begin
        single_load   = 1'b1;
        single_status = cmd.status;
      end
    endcase
    if (rd_issue) begin
      rd_slot_nxt = inc_slot(rd_slot_r);
      rem_nxt     = rem_r - 1'b1;
    end
    if (shift_wr) begin
      mem_we      = 1'b1;
      mem_wa      = wr_slot_r;
      mem_wd      = rd_data_r;
      wr_slot_nxt = inc_slot(wr_slot_r);
    end
  end

  // Store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_slot_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rem_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Stream pointers
  always_ff @(posedge clk) begin
    rd_slot_r <= rd_slot_nxt;
    wr_slot_r <= wr_slot_nxt;
    if (rd_issue) begin
      last_pend_r <= (rem_r == CNT_W'(1));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (single_load || load_elem) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (single_load) begin
      out_status_r        <= single_status;
      out_element_r       <= '0;
      out_element_valid_r <= 1'b0;
      out_last_r          <= 1'b1;
      out_length_r        <= LEN_W'(count_nxt);
    end else if (load_elem) begin
      out_status_r        <= STS_OK;
      out_element_r       <= rd_data_r;
      out_element_valid_r <= 1'b1;
      out_last_r          <= last_pend_r;
      out_length_r        <= LEN_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element       = out_element_r;
  assign out_element_valid = out_element_valid_r;
  assign out_last          = out_last_r;
  assign out_length        = out_length_r;

endmodule

`default_nettype wire

[src/bole_ctrl.sv]
`default_nettype none

module bole_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire [bole_pkg::ACTION_W-1:0]  in_action,
  output bole_pkg::dp_cmd_t             cmd,
  input  bole_pkg::dp_sts_t             sts
);

  import bole_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DUMP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // New transactions only in idle, and only with room in the result register
  assign in_stall = (state_r != ST_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.status   = STS_OK;
    cmd.shift_en = (state_r == ST_SHIFT);
    cmd.dump_en  = (state_r == ST_DUMP);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (sts.full) begin
                cmd.op     = OP_REPORT;
                cmd.status = STS_FULL;
              end else begin
                cmd.op = (in_action == ACT_INS_FRONT) ? OP_INS_FRONT : OP_INS_BACK;
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK: begin
              if (sts.empty) begin
                cmd.op     = OP_REPORT;
                cmd.status = STS_EMPTY;
              end else begin
                cmd.op = (in_action == ACT_DEL_FRONT) ? OP_DEL_FRONT : OP_DEL_BACK;
              end
            end
            ACT_DEL_POS: begin
              if (sts.empty) begin
                cmd.op     = OP_REPORT;
                cmd.status = STS_EMPTY;
              end else if (!sts.pos_ok) begin
                cmd.op     = OP_REPORT;
                cmd.status = STS_BADPOS;
              end else begin
                cmd.op = OP_DEL_POS;
                if (!sts.no_moves) begin
                  state_nxt = ST_SHIFT;
                end
              end
            end
            ACT_READ_ALL: begin
              if (sts.empty) begin
                cmd.op = OP_REPORT;
              end else begin
                cmd.op    = OP_DUMP;
                state_nxt = ST_DUMP;
              end
            end
            default: begin
              cmd.op = OP_REPORT;
            end
          endcase
        end
      end
      ST_SHIFT, ST_DUMP: begin
        if (sts.stream_idle) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/bounded_ordered_list_engine_top.sv]
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | action, value, position
// out_     | output    | out_valid/out_stall| status, element, element_valid, last, length
//
// Insert, delete front/back and rejected actions give one result.
// Delete at position gives one result and, unless it hits the back entry, compacts the
// entries behind it through the store's single read and write port, one entry a cycle.
// Read all gives one result a cycle while the output is not stalled.
// rst_n is synchronous; the store itself is not cleared and needs no pass.
// A held result stalls the input; a stalled read-out pauses the store reads.

module bounded_ordered_list_engine_top #(
  parameter int DEPTH = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire [bole_pkg::ACTION_W-1:0]        in_action,
  input  wire signed [bole_pkg::VALUE_W-1:0]  in_value,
  input  wire [bole_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [bole_pkg::STATUS_W-1:0]       out_status,
  output logic signed [bole_pkg::VALUE_W-1:0] out_element,
  output logic                                out_element_valid,
  output logic                                out_last,
  output logic [bole_pkg::LEN_W-1:0]          out_length
);

  import bole_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .cmd       (cmd),
    .sts       (sts)
  );

  bole_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_last          (out_last),
    .out_length        (out_length)
  );

endmodule

`default_nettype wire

[src/bole_checker.sv]
`default_nettype none

module bole_checker #(
  parameter int DEPTH = 64
) (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_valid,
  input wire                                 in_stall,
  input wire [bole_pkg::ACTION_W-1:0]        in_action,
  input wire signed [bole_pkg::VALUE_W-1:0]  in_value,
  input wire [bole_pkg::POS_W-1:0]           in_position,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire [bole_pkg::STATUS_W-1:0]        out_status,
  input wire signed [bole_pkg::VALUE_W-1:0]  out_element,
  input wire                                 out_element_valid,
  input wire                                 out_last,
  input wire [bole_pkg::LEN_W-1:0]           out_length
);

  import bole_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_element) && $stable(out_element_valid) &&
      $stable(out_last) && $stable(out_length))
    else $error("result changed while stalled");

  // Results without an element are single-result transactions
  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_element_valid |-> out_last && (out_element == '0))
    else $error("plain result not last or element not zero");

  // Elements come only from a non-empty list with status ok
  a_elem_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_valid |-> (out_status == STS_OK) && (out_length != '0))
    else $error("element with bad status or zero length");

  // Length never exceeds the store, and full means full
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= LEN_W'(DEPTH)) &&
      ((out_status != STS_FULL) || (out_length == LEN_W'(DEPTH))))
    else $error("length out of range or inconsistent with full status");

  // Empty report only with an empty list
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_EMPTY) |-> (out_length == '0))
    else $error("empty status with non-zero length");

endmodule

bind bounded_ordered_list_engine_top bole_checker #(
  .DEPTH (DEPTH)
) u_bole_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_action         (in_action),
  .in_value          (in_value),
  .in_position       (in_position),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_element       (out_element),
  .out_element_valid (out_element_valid),
  .out_last          (out_last),
  .out_length        (out_length)
);

`default_nettype wire
